### rtl/block_average_downscale_top_defines.svh
// ----------------------------------------------------------------------------
// block_average_downscale_top_defines
// Assertion macros for the checker file of the downscaler.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_DOWNSCALE_TOP_DEFINES_SVH
`define BLOCK_AVERAGE_DOWNSCALE_TOP_DEFINES_SVH

// Same-cycle implication
`define BAD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BAD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bad_pkg.sv
// ----------------------------------------------------------------------------
// bad_pkg
// Constants, widths and register indexes of the block average downscaler.
// ----------------------------------------------------------------------------
package bad_pkg;

   // parameter defaults
   localparam int MAX_COLS_DEF   = 4096;
   localparam int MAX_FACTOR_DEF = 16;
   localparam int PIXEL_BITS_DEF = 16;

   // fixed frame limits and field widths
   localparam int MAX_ROWS  = 4096;
   localparam int ROWS_W    = 13;
   localparam int ROW_W     = 12;
   localparam int PIXEL_W   = 16;
   localparam int AVG_W     = 16;
   localparam int OUT_POS_W = 12;
   localparam int FAC_W     = 5;
   localparam int CM_W      = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_FACTOR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_FACTOR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CROP_MULT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_ZERO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_ROWS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_COLS = 3'd5;

   // register reset values
   localparam logic [FAC_W-1:0]  RST_FACTOR = 5'd1;
   localparam logic [CM_W-1:0]   RST_CROP   = 7'd1;
   localparam logic [ROWS_W-1:0] RST_ROWS   = 13'd480;
   localparam logic [ROWS_W-1:0] RST_COLS   = 13'd640;

endpackage

### rtl/bad_ram.sv
// ----------------------------------------------------------------------------
// bad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bad_div.sv
// ----------------------------------------------------------------------------
// bad_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module bad_div #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [DEN_W:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      trial   = {r_ff, q_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         q_in    = num;
         r_in    = '0;
         d_in    = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = DEN_W'(trial - {1'b0, d_ff});
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = DEN_W'(trial);
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;

endmodule

### rtl/block_average_downscale_top.sv
// Flow: a pixel outside the cropped region is taken in S_IDLE, one inside also passes S_UPD
// (line store read, then write back); a block's last pixel then goes through the divider
// (S_DIV, skipped when no pixel counted) and S_HOLD, where a stalled result beat holds it.
// A pixel inside the region is not taken until its read-modify-write is done.
// Reset: a clearing pass writes MAX_COLS entries, then six divisions recompute the
// geometry, as after any register write.
// ----------------------------------------------------------------------------
// block_average_downscale_top
// Block average image downscaler with a per-column line store.
// ----------------------------------------------------------------------------
module block_average_downscale_top #(
   parameter int MAX_COLS   = bad_pkg::MAX_COLS_DEF,
   parameter int MAX_FACTOR = bad_pkg::MAX_FACTOR_DEF,
   parameter int PIXEL_BITS = bad_pkg::PIXEL_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bad_pkg::PIXEL_W-1:0]          req_pixel_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bad_pkg::AVG_W-1:0]            rsp_average_value,
   output logic [bad_pkg::OUT_POS_W-1:0]        rsp_out_row,
   output logic [bad_pkg::OUT_POS_W-1:0]        rsp_out_col,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bad_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bad_pkg::CSR_DAT_W-1:0]        csr_data
);

   localparam int CW      = $clog2(MAX_COLS);
   localparam int CCW     = $clog2(MAX_COLS + 1);
   localparam int FAC_LOG = $clog2(MAX_FACTOR);
   localparam int PIX_USE = (PIXEL_BITS < bad_pkg::PIXEL_W) ? PIXEL_BITS : bad_pkg::PIXEL_W;
   localparam int SUM_W   = PIX_USE + 2 * FAC_LOG;
   localparam int CNT_W   = 2 * FAC_LOG + 1;
   localparam int NUM_A   = (SUM_W + 1 > CCW) ? SUM_W + 1 : CCW;
   localparam int NUM_W   = (NUM_A > bad_pkg::ROWS_W) ? NUM_A : bad_pkg::ROWS_W;
   localparam int DEN_W   = (CNT_W > bad_pkg::CM_W) ? CNT_W : bad_pkg::CM_W;
   localparam int FW      = bad_pkg::FAC_W;
   localparam int RW      = bad_pkg::ROW_W;
   localparam int RSW     = bad_pkg::ROWS_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_GEO   = 3'd1;
   localparam logic [2:0] S_IDLE  = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_HOLD  = 3'd5;

   localparam logic [2:0] G_ROWS = 3'd0;
   localparam logic [2:0] G_COLS = 3'd1;
   localparam logic [2:0] G_DROW = 3'd2;
   localparam logic [2:0] G_DCOL = 3'd3;
   localparam logic [2:0] G_RPOS = 3'd4;
   localparam logic [2:0] G_CPOS = 3'd5;

   // configuration registers
   logic [FW-1:0]                rowf_ff, rowf_in;
   logic [FW-1:0]                colf_ff, colf_in;
   logic [bad_pkg::CM_W-1:0]     crop_ff, crop_in;
   logic                         skip_ff, skip_in;
   logic [RSW-1:0]               srows_ff, srows_in;
   logic [RSW-1:0]               scols_ff, scols_in;

   // position and geometry
   logic [RW-1:0]                r_ff, r_in, dr_ff, dr_in;
   logic [CW-1:0]                c_ff, c_in, dc_ff, dc_in;
   logic [FW-1:0]                rr_ff, rr_in, cc_ff, cc_in;
   logic [RSW-1:0]               qrows_ff, qrows_in, drows_ff, drows_in;
   logic [CCW-1:0]               qcols_ff, qcols_in, dcols_ff, dcols_in;

   // control
   logic [2:0]                   state_ff, state_in;
   logic [2:0]                   gstep_ff, gstep_in;
   logic                         gwait_ff, gwait_in;
   logic [CW-1:0]                clr_ff, clr_in;

   // item in flight
   logic [PIX_USE-1:0]           pix_ff, pix_in;
   logic                         cnt_en_ff, cnt_en_in;
   logic                         emit_ff, emit_in;
   logic [CW-1:0]                dci_ff, dci_in;
   logic [RW-1:0]                dri_ff, dri_in;
   logic                         flast_ff, flast_in;
   logic [bad_pkg::AVG_W-1:0]    avg_ff, avg_in;

   // result register
   logic                         rv_ff, rv_in;
   logic [bad_pkg::AVG_W-1:0]    ravg_ff, ravg_in;
   logic [bad_pkg::OUT_POS_W-1:0] rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic                         rlast_ff, rlast_in;

   // derived values
   logic [FW-1:0]                rf, cf;
   logic [bad_pkg::CM_W-1:0]     cm;
   logic [RSW-1:0]               rows;
   logic [CCW-1:0]               cols;
   logic                         accept, in_reg, blk_last, frm_last, pix_cnt;
   logic [PIX_USE-1:0]           pix;

   // line store and divider
   logic                         wr_en;
   logic [CW-1:0]                wr_addr;
   logic [SUM_W+CNT_W-1:0]       wr_data, rd_data;
   logic [SUM_W-1:0]             old_sum, new_sum;
   logic [CNT_W-1:0]             old_cnt, new_cnt;
   logic                         div_start, div_done;
   logic [NUM_W-1:0]             div_num, div_quo;
   logic [DEN_W-1:0]             div_den, div_rem;

   // clamped geometry
   always_comb begin
      rf = rowf_ff;
      if (rowf_ff == '0) begin
         rf = FW'(1);
      end else if (int'(rowf_ff) > MAX_FACTOR) begin
         rf = FW'(MAX_FACTOR);
      end
      cf = colf_ff;
      if (colf_ff == '0) begin
         cf = FW'(1);
      end else if (int'(colf_ff) > MAX_FACTOR) begin
         cf = FW'(MAX_FACTOR);
      end
      cm = (crop_ff == '0) ? bad_pkg::CM_W'(1) : crop_ff;
      rows = srows_ff;
      if (srows_ff == '0) begin
         rows = RSW'(1);
      end else if (int'(srows_ff) > bad_pkg::MAX_ROWS) begin
         rows = RSW'(bad_pkg::MAX_ROWS);
      end
      cols = CCW'(scols_ff);
      if (scols_ff == '0) begin
         cols = CCW'(1);
      end else if (int'(scols_ff) > MAX_COLS) begin
         cols = CCW'(MAX_COLS);
      end
   end

   // pixel classification at acceptance
   assign accept   = req_valid && !req_stall;
   assign pix      = req_pixel_value[PIX_USE-1:0];
   assign pix_cnt  = !(skip_ff && (pix == '0));
   assign in_reg   = (RSW'(dr_ff) < drows_ff) && (CCW'(dc_ff) < dcols_ff);
   assign blk_last = (rr_ff == rf - FW'(1)) && (cc_ff == cf - FW'(1));
   assign frm_last = (RSW'(dr_ff) == drows_ff - RSW'(1))
                     && (CCW'(dc_ff) == dcols_ff - CCW'(1));

   // line store entry update
   assign old_sum = rd_data[SUM_W+CNT_W-1:CNT_W];
   assign old_cnt = rd_data[CNT_W-1:0];
   assign new_sum = old_sum + (cnt_en_ff ? SUM_W'(pix_ff) : SUM_W'(0));
   assign new_cnt = old_cnt + CNT_W'(cnt_en_ff);

   // main sequencer
   always_comb begin
      rowf_in   = rowf_ff;
      colf_in   = colf_ff;
      crop_in   = crop_ff;
      skip_in   = skip_ff;
      srows_in  = srows_ff;
      scols_in  = scols_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      rr_in     = rr_ff;
      cc_in     = cc_ff;
      dr_in     = dr_ff;
      dc_in     = dc_ff;
      qrows_in  = qrows_ff;
      qcols_in  = qcols_ff;
      drows_in  = drows_ff;
      dcols_in  = dcols_ff;
      state_in  = state_ff;
      gstep_in  = gstep_ff;
      gwait_in  = gwait_ff;
      clr_in    = clr_ff;
      pix_in    = pix_ff;
      cnt_en_in = cnt_en_ff;
      emit_in   = emit_ff;
      dci_in    = dci_ff;
      dri_in    = dri_ff;
      flast_in  = flast_ff;
      avg_in    = avg_ff;
      rv_in     = rv_ff;
      ravg_in   = ravg_ff;
      rrow_in   = rrow_ff;
      rcol_in   = rcol_ff;
      rlast_in  = rlast_ff;
      wr_en     = 1'b0;
      wr_addr   = dci_ff;
      wr_data   = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = DEN_W'(1);

      // result beat taken
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == CW'(MAX_COLS - 1)) begin
               state_in = S_GEO;
               gstep_in = G_ROWS;
               gwait_in = 1'b0;
            end else begin
               clr_in = clr_ff + CW'(1);
            end
         end
         S_GEO: begin
            case (gstep_ff)
               G_ROWS:  begin div_num = NUM_W'(rows);     div_den = DEN_W'(rf); end
               G_COLS:  begin div_num = NUM_W'(cols);     div_den = DEN_W'(cf); end
               G_DROW:  begin div_num = NUM_W'(qrows_ff); div_den = DEN_W'(cm); end
               G_DCOL:  begin div_num = NUM_W'(qcols_ff); div_den = DEN_W'(cm); end
               G_RPOS:  begin div_num = NUM_W'(r_ff);     div_den = DEN_W'(rf); end
               G_CPOS:  begin div_num = NUM_W'(c_ff);     div_den = DEN_W'(cf); end
               default: begin div_num = '0;               div_den = DEN_W'(1);  end
            endcase
            if (!gwait_ff) begin
               div_start = 1'b1;
               gwait_in  = 1'b1;
            end else if (div_done) begin
               gwait_in = 1'b0;
               gstep_in = gstep_ff + 3'd1;
               case (gstep_ff)
                  G_ROWS: qrows_in = RSW'(div_quo);
                  G_COLS: qcols_in = CCW'(div_quo);
                  G_DROW: drows_in = RSW'(RSW'(div_quo) * cm);
                  G_DCOL: dcols_in = CCW'(CCW'(div_quo) * cm);
                  G_RPOS: begin
                     dr_in = RW'(div_quo);
                     rr_in = FW'(div_rem);
                  end
                  G_CPOS: begin
                     dc_in    = CW'(div_quo);
                     cc_in    = FW'(div_rem);
                     state_in = S_IDLE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_IDLE: begin
            if (csr_valid) begin
               state_in = S_GEO;
               gstep_in = G_ROWS;
               gwait_in = 1'b0;
            end else if (accept) begin
               pix_in    = pix;
               cnt_en_in = pix_cnt;
               emit_in   = blk_last;
               dci_in    = dc_ff;
               dri_in    = dr_ff;
               flast_in  = frm_last;
               if (in_reg) begin
                  state_in = S_UPD;
               end
               // advance source position
               if ((CCW'(c_ff) + CCW'(1)) >= cols) begin
                  c_in  = '0;
                  cc_in = '0;
                  dc_in = '0;
                  if ((RSW'(r_ff) + RSW'(1)) >= rows) begin
                     r_in  = '0;
                     rr_in = '0;
                     dr_in = '0;
                  end else begin
                     r_in = r_ff + RW'(1);
                     if ((rr_ff + FW'(1)) >= rf) begin
                        rr_in = '0;
                        dr_in = dr_ff + RW'(1);
                     end else begin
                        rr_in = rr_ff + FW'(1);
                     end
                  end
               end else begin
                  c_in = c_ff + CW'(1);
                  if ((cc_ff + FW'(1)) >= cf) begin
                     cc_in = '0;
                     dc_in = dc_ff + CW'(1);
                  end else begin
                     cc_in = cc_ff + FW'(1);
                  end
               end
            end
         end
         S_UPD: begin
            wr_en   = 1'b1;
            wr_addr = dci_ff;
            if (emit_ff) begin
               wr_data = '0;
               div_num = NUM_W'(new_sum) + NUM_W'(new_cnt >> 1);
               div_den = DEN_W'(new_cnt);
               if (new_cnt == '0) begin
                  avg_in   = '0;
                  state_in = S_HOLD;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else begin
               wr_data  = {new_sum, new_cnt};
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               avg_in   = bad_pkg::AVG_W'(div_quo);
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               ravg_in  = avg_ff;
               rrow_in  = bad_pkg::OUT_POS_W'(dri_ff);
               rcol_in  = bad_pkg::OUT_POS_W'(dci_ff);
               rlast_in = flast_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bad_pkg::REG_ROW_FACTOR:  rowf_in  = csr_data[FW-1:0];
            bad_pkg::REG_COL_FACTOR:  colf_in  = csr_data[FW-1:0];
            bad_pkg::REG_CROP_MULT:   crop_in  = csr_data[bad_pkg::CM_W-1:0];
            bad_pkg::REG_SKIP_ZERO:   skip_in  = csr_data[0];
            bad_pkg::REG_SOURCE_ROWS: srows_in = csr_data[RSW-1:0];
            bad_pkg::REG_SOURCE_COLS: scols_in = csr_data[RSW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rowf_ff  <= bad_pkg::RST_FACTOR;
         colf_ff  <= bad_pkg::RST_FACTOR;
         crop_ff  <= bad_pkg::RST_CROP;
         skip_ff  <= 1'b0;
         srows_ff <= bad_pkg::RST_ROWS;
         scols_ff <= bad_pkg::RST_COLS;
         r_ff     <= '0;
         c_ff     <= '0;
         state_ff <= S_CLEAR;
         gstep_ff <= G_ROWS;
         gwait_ff <= 1'b0;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         rowf_ff  <= rowf_in;
         colf_ff  <= colf_in;
         crop_ff  <= crop_in;
         skip_ff  <= skip_in;
         srows_ff <= srows_in;
         scols_ff <= scols_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         state_ff <= state_in;
         gstep_ff <= gstep_in;
         gwait_ff <= gwait_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      rr_ff     <= rr_in;
      cc_ff     <= cc_in;
      dr_ff     <= dr_in;
      dc_ff     <= dc_in;
      qrows_ff  <= qrows_in;
      qcols_ff  <= qcols_in;
      drows_ff  <= drows_in;
      dcols_ff  <= dcols_in;
      pix_ff    <= pix_in;
      cnt_en_ff <= cnt_en_in;
      emit_ff   <= emit_in;
      dci_ff    <= dci_in;
      dri_ff    <= dri_in;
      flast_ff  <= flast_in;
      avg_ff    <= avg_in;
      ravg_ff   <= ravg_in;
      rrow_ff   <= rrow_in;
      rcol_ff   <= rcol_in;
      rlast_ff  <= rlast_in;
   end

   // per-column sums and counts
   bad_ram #(
      .WIDTH (SUM_W + CNT_W),
      .DEPTH (MAX_COLS)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (dc_ff),
      .rd_data (rd_data)
   );

   // shared divider: geometry and block averages
   bad_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // a pending register write takes priority over a pixel
   assign req_stall         = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready         = (state_ff == S_IDLE) || (state_ff == S_CLEAR);
   assign rsp_valid         = rv_ff;
   assign rsp_average_value = ravg_ff;
   assign rsp_out_row       = rrow_ff;
   assign rsp_out_col       = rcol_ff;
   assign rsp_frame_last    = rlast_ff;

endmodule

### rtl/bad_checker.sv
// ----------------------------------------------------------------------------
// bad_checker
// Port-level checks of the block average downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_average_downscale_top_defines.svh"

module bad_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bad_pkg::AVG_W-1:0]     rsp_average_value,
   input logic [bad_pkg::OUT_POS_W-1:0] rsp_out_row,
   input logic [bad_pkg::OUT_POS_W-1:0] rsp_out_col,
   input logic                          rsp_frame_last,
   input logic                          csr_valid,
   input logic                          csr_ready
);

   // a stalled result beat holds
   `BAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_average_value) && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_last), "stalled result beat changed")

   // line store clearing pass follows reset
   `BAD_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, req_stall && !rsp_valid, "pixel taken or result shown right after reset")

   // a register write forces a geometry recompute
   `BAD_ASSERT_NEXT(a_csr_recompute, clock, reset, csr_valid && csr_ready, req_stall, "pixel taken before geometry recompute")

endmodule

bind block_average_downscale_top bad_checker u_bad_checker (.*);
